>>> src/pfbc_pkg.sv
// Package for the page framebuffer blit/clear block: request codes, command
// format between the front and back parts, and back-end state encoding.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package pfbc_pkg;

    // Default geometry of the store.
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 64;

    // Rows held by one byte of a page.
    localparam int PAGE_ROWS = 8;

    // Command fields are sized for the largest supported geometry:
    // up to 256 columns and up to 64 pages.
    localparam int COL_BITS  = 8;
    localparam int PAGE_BITS = 6;

    // Width used for bounds arithmetic on the request fields.
    localparam int BND_BITS = 10;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Field widths of the streams.
    localparam int S_TDATA_BITS = 56;
    localparam int M_TDATA_BITS = 8;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 8;

    // Request codes carried in s_tuser.
    localparam logic [1:0] REQ_MERGE = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd1;

    // Status codes of a result.
    localparam logic STAT_DONE   = 1'b0;
    localparam logic STAT_REJECT = 1'b1;

    typedef enum logic [2:0] {
        OP_REJECT,
        OP_DONE,
        OP_READ,
        OP_MERGE,
        OP_CLEAR
    } op_t;

    // One classified request, ready for the back part.
    typedef struct packed {
        op_t                  op;
        logic [PAGE_BITS-1:0] page_first;
        logic [PAGE_BITS-1:0] page_last;
        logic [COL_BITS-1:0]  col_first;
        logic [COL_BITS-1:0]  col_last;
        logic [7:0]           set0;
        logic [7:0]           set1;
        logic                 spill;
        logic [7:0]           mask_top;
        logic [7:0]           mask_bot;
    } cmd_t;

    // Status reported by the back part to the front part.
    typedef struct packed {
        logic init_busy;
    } back_status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_RESP
    } back_state_t;

endpackage

>>> src/pfbc_front.sv
// Front part: accepts requests, holds the configuration registers and turns
// each request into a command for the back part.
// Depends on pfbc_pkg.
`timescale 1ns / 1ps

module pfbc_front
    import pfbc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_BITS-1:0]  s_tdata,
    input  logic [1:0]               s_tuser,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  back_status_t             back_status,
    input  logic                     q_full,
    output logic                     q_push,
    output cmd_t                     q_cmd
);

    logic [7:0] width_reg;
    logic [6:0] height_reg;

    logic [BND_BITS-1:0] x, y, w, h, col, pg, ew, eh, xw, yh, yh1, dpage, last_pg;
    logic [7:0]  b;
    logic [2:0]  shift;
    logic [15:0] shifted;
    logic        in_bounds;
    logic [2:0]  bot_row;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 8'd128;
            height_reg <= 7'd64;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Unpack the request fields.
    assign x     = BND_BITS'(s_tdata[7:0]);
    assign y     = BND_BITS'(s_tdata[14:8]);
    assign w     = BND_BITS'(s_tdata[22:15]);
    assign h     = BND_BITS'(s_tdata[29:23]);
    assign col   = BND_BITS'(s_tdata[36:30]);
    assign pg    = BND_BITS'(s_tdata[40:37]);
    assign b     = s_tdata[48:41];

    // Effective geometry and bounds.
    assign ew = (BND_BITS'(width_reg) > BND_BITS'(MAX_WIDTH)) ?
                BND_BITS'(MAX_WIDTH) : BND_BITS'(width_reg);
    assign eh = (BND_BITS'(height_reg) > BND_BITS'(MAX_HEIGHT)) ?
                BND_BITS'(MAX_HEIGHT) : BND_BITS'(height_reg);
    assign last_pg   = eh >> 3;
    assign xw        = x + w;
    assign yh        = y + h;
    assign yh1       = yh - BND_BITS'(1);
    assign in_bounds = (xw <= ew) && (yh <= eh);
    assign shift     = y[2:0];
    assign shifted   = {8'd0, b} << shift;
    assign dpage     = (y >> 3) + pg;
    assign bot_row   = yh1[2:0];

    // Classify the request into a command.
    always_comb begin
        q_cmd            = '0;
        q_cmd.op         = OP_REJECT;
        q_cmd.set0       = shifted[7:0];
        q_cmd.set1       = shifted[15:8];
        q_cmd.mask_top   = 8'hFF << shift;
        q_cmd.mask_bot   = 8'hFF >> (3'd7 - bot_row);
        case (s_tuser)
            REQ_MERGE: begin
                if (in_bounds && (col < w) && (pg <= (h >> 3))) begin
                    q_cmd.op = OP_MERGE;
                end
                q_cmd.page_first = dpage[PAGE_BITS-1:0];
                q_cmd.page_last  = dpage[PAGE_BITS-1:0];
                q_cmd.col_first  = COL_BITS'(x + col);
                q_cmd.col_last   = COL_BITS'(x + col);
                q_cmd.spill      = (shift != 3'd0) && ((dpage + BND_BITS'(1)) <= last_pg);
            end
            REQ_CLEAR: begin
                if (in_bounds) begin
                    q_cmd.op = ((w == '0) || (h == '0)) ? OP_DONE : OP_CLEAR;
                end
                q_cmd.page_first = PAGE_BITS'(y >> 3);
                q_cmd.page_last  = PAGE_BITS'(yh1 >> 3);
                q_cmd.col_first  = COL_BITS'(x);
                q_cmd.col_last   = COL_BITS'(xw - BND_BITS'(1));
            end
            REQ_READ: begin
                if ((col < ew) && (pg <= last_pg)) begin
                    q_cmd.op = OP_READ;
                end
                q_cmd.page_first = PAGE_BITS'(pg);
                q_cmd.page_last  = PAGE_BITS'(pg);
                q_cmd.col_first  = COL_BITS'(col);
                q_cmd.col_last   = COL_BITS'(col);
            end
            default: ;
        endcase
    end

    // A request is taken while the queue has room and the store is ready.
    assign s_tready = !q_full && !back_status.init_busy;
    assign q_push   = s_tvalid && s_tready;

endmodule

>>> src/pfbc_queue.sv
// Short command queue between the front and back parts.
// Depends on pfbc_pkg for the command type and the depth.
`timescale 1ns / 1ps

module pfbc_queue
    import pfbc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic nonempty,
    output cmd_t head_cmd
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    assign full     = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    // Entries carry no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                              wr_ptr_reg + PTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                              rd_ptr_reg + PTR_BITS'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_BITS'(1);
                2'b01:   count_reg <= count_reg - CNT_BITS'(1);
                default: ;
            endcase
        end
    end

endmodule

>>> src/pfbc_back.sv
// Back part: owns the frame store memory, clears it after reset and carries
// out merge and clear commands as read-modify-write steps and read commands as reads.
// Depends on pfbc_pkg.
`timescale 1ns / 1ps

module pfbc_back
    import pfbc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_nonempty,
    input  cmd_t                    q_cmd,
    output logic                    q_pop,
    output back_status_t            back_status,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata,
    output logic                    m_tuser
);

    localparam int PAGE_COUNT = MAX_HEIGHT / PAGE_ROWS + 1;
    localparam int DEPTH      = PAGE_COUNT * MAX_WIDTH;
    localparam int AW         = $clog2(DEPTH);

    back_state_t          state_reg, state_next;
    cmd_t                 cmd_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [COL_BITS-1:0]  col_reg;
    logic                 second_reg;
    logic [AW-1:0]        init_cnt_reg;
    logic [7:0]           rd_data_reg;
    logic                 out_valid_reg;
    logic                 out_status_reg;
    logic [7:0]           out_byte_reg;

    logic [7:0] mem [DEPTH];

    logic          out_free;
    logic [AW-1:0] cur_addr;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [7:0]    clear_mask;
    logic          step_last, col_last, page_last;
    logic          out_load, out_status;
    logic [7:0]    out_byte;

    assign out_free              = !out_valid_reg || m_tready;
    assign cur_addr              = AW'(32'(page_reg) * 32'(MAX_WIDTH) + 32'(col_reg));
    assign back_status.init_busy = (state_reg == ST_INIT);

    // Progress through the bytes of the current command.
    assign col_last  = (col_reg == cmd_reg.col_last);
    assign page_last = (page_reg == cmd_reg.page_last);
    assign step_last = (cmd_reg.op == OP_MERGE) ? (second_reg || !cmd_reg.spill) :
                       (col_last && page_last);
    assign clear_mask = ((page_reg == cmd_reg.page_first) ? cmd_reg.mask_top : 8'hFF) &
                        (page_last ? cmd_reg.mask_bot : 8'hFF);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (init_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_nonempty && out_free) begin
                    case (q_cmd.op)
                        OP_READ, OP_MERGE, OP_CLEAR: state_next = ST_RD;
                        default:                     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD: begin
                state_next = (cmd_reg.op == OP_READ) ? ST_RESP : ST_WR;
            end
            ST_WR: begin
                state_next = step_last ? ST_IDLE : ST_RD;
            end
            ST_RESP: begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    // Outputs of each state.
    always_comb begin
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = cur_addr;
        mem_wdata  = 8'd0;
        out_load   = 1'b0;
        out_status = STAT_DONE;
        out_byte   = 8'd0;
        unique case (state_reg)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = init_cnt_reg;
            end
            ST_IDLE: begin
                if (q_nonempty && out_free) begin
                    q_pop = 1'b1;
                    if (q_cmd.op == OP_REJECT) begin
                        out_load   = 1'b1;
                        out_status = STAT_REJECT;
                    end else if (q_cmd.op == OP_DONE) begin
                        out_load = 1'b1;
                    end
                end
            end
            ST_RD: begin
                mem_re = 1'b1;
            end
            ST_WR: begin
                mem_we = 1'b1;
                if (cmd_reg.op == OP_MERGE) begin
                    mem_wdata = rd_data_reg | (second_reg ? cmd_reg.set1 : cmd_reg.set0);
                end else begin
                    mem_wdata = rd_data_reg & ~clear_mask;
                end
                out_load = step_last;
            end
            ST_RESP: begin
                out_load = 1'b1;
                out_byte = rd_data_reg;
            end
            default: ;
        endcase
    end

    // Frame store with registered read data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[cur_addr];
        end
    end

    // Command datapath registers.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg    <= q_cmd;
            page_reg   <= q_cmd.page_first;
            col_reg    <= q_cmd.col_first;
            second_reg <= 1'b0;
        end else if (state_reg == ST_WR && !step_last) begin
            if (cmd_reg.op == OP_MERGE) begin
                second_reg <= 1'b1;
                page_reg   <= page_reg + PAGE_BITS'(1);
            end else if (col_last) begin
                col_reg  <= cmd_reg.col_first;
                page_reg <= page_reg + PAGE_BITS'(1);
            end else begin
                col_reg <= col_reg + COL_BITS'(1);
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg <= out_status;
            out_byte_reg   <= out_byte;
        end
    end

    // State, clearing pass counter and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            init_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_INIT) begin
                init_cnt_reg <= init_cnt_reg + AW'(1);
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_status_reg;

endmodule

>>> src/page_framebuffer_blit_clear.sv
// Top level of the page framebuffer blit/clear block.
// Depends on pfbc_pkg, pfbc_front, pfbc_queue and pfbc_back.
//
//   Channel   Direction  Handshake             Payload
//   s_        in         s_tvalid / s_tready   request fields in s_tdata, type in s_tuser
//   m_        out        m_tvalid / m_tready   read byte in m_tdata, status in m_tuser
//   cfg_      in         cfg_valid / cfg_ready register index and data
//
// After reset the store is swept to zero, one byte a cycle, over all
// (MAX_HEIGHT/8+1)*MAX_WIDTH bytes (1152 by default); no request is taken then.
// Every byte of a merge or a clear goes through the memory as a read then a
// write. The command queue keeps taking requests while it has room, also
// while the back end works or waits on m_tready.
`timescale 1ns / 1ps

module page_framebuffer_blit_clear
    import pfbc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // rect_x[7:0], rect_y[14:8], rect_w[22:15], rect_h[29:23], column[36:30],
    // page[40:37], src_byte[48:41], zero fill above
    input  logic [S_TDATA_BITS-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [1:0]               s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // read_byte[7:0]
    output logic [M_TDATA_BITS-1:0]  m_tdata,
    // status[0]
    output logic                     m_tuser,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    back_status_t back_status;
    logic         q_full, q_push, q_pop, q_nonempty;
    cmd_t         push_cmd, head_cmd;

    pfbc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .back_status (back_status),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    pfbc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .head_cmd (head_cmd)
    );

    pfbc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_nonempty  (q_nonempty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .back_status (back_status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

>>> tb/pfbc_checker.sv
// Checker for the page framebuffer blit/clear block: mirrors the frame store,
// predicts every result from the accepted requests and compares it. Depends on pfbc_pkg.
`timescale 1ns / 1ps

module pfbc_checker
    import pfbc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [S_TDATA_BITS-1:0]  s_tdata,
    input  logic [1:0]               s_tuser,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [M_TDATA_BITS-1:0]  m_tdata,
    input  logic                     m_tuser,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                       fail_count,
    output int                       pending_count
);

    localparam int FB_W     = DEF_MAX_WIDTH;
    localparam int FB_H     = DEF_MAX_HEIGHT;
    localparam int FB_PAGES = FB_H / PAGE_ROWS + 1;

    typedef struct packed {
        logic       status;
        logic [7:0] rd_byte;
    } outcome_t;

    logic [7:0] shadow_fb [FB_PAGES*FB_W];
    int unsigned cols_used, rows_used;
    outcome_t expected_q[$];

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        fail_count++;
    endtask

    function automatic int unsigned eff_cols();
        return cols_used > FB_W ? FB_W : cols_used;
    endfunction

    function automatic int unsigned eff_rows();
        return rows_used > FB_H ? FB_H : rows_used;
    endfunction

    // Apply one request to the shadow store and return the expected result.
    function automatic outcome_t apply_request(input logic [1:0] kind,
                                               input logic [S_TDATA_BITS-1:0] d);
        int unsigned x, y, w, h, col, pg, b, ew, eh, sh, dp, dc, first, last, top, bot;
        logic [7:0] msk;
        outcome_t r;
        x = d[7:0]; y = d[14:8]; w = d[22:15]; h = d[29:23];
        col = d[36:30]; pg = d[40:37]; b = d[48:41];
        ew = eff_cols(); eh = eff_rows();
        r.status = STAT_REJECT;
        r.rd_byte = 8'd0;
        case (kind)
            REQ_MERGE: begin
                if (x + w <= ew && y + h <= eh && col < w && pg <= h / PAGE_ROWS) begin
                    r.status = STAT_DONE;
                    sh = y % PAGE_ROWS;
                    dp = y / PAGE_ROWS + pg;
                    dc = x + col;
                    if (dp < FB_PAGES && dc < FB_W)
                        shadow_fb[dp*FB_W+dc] |= 8'((b << sh) & 'hFF);
                    if (sh > 0 && dp + 1 <= eh / PAGE_ROWS && dp + 1 < FB_PAGES && dc < FB_W)
                        shadow_fb[(dp+1)*FB_W+dc] |= 8'((b >> (PAGE_ROWS - sh)) & 'hFF);
                end
            end
            REQ_CLEAR: begin
                if (x + w <= ew && y + h <= eh) begin
                    r.status = STAT_DONE;
                    if (w != 0 && h != 0) begin
                        first = y / PAGE_ROWS;
                        last = (y + h - 1) / PAGE_ROWS;
                        for (int unsigned p = first; p <= last && p < FB_PAGES; p++) begin
                            top = (p == first) ? y % PAGE_ROWS : 0;
                            bot = (p == last) ? (y + h - 1) % PAGE_ROWS : PAGE_ROWS - 1;
                            msk = 8'((8'hFF << top) & (8'hFF >> (PAGE_ROWS - 1 - bot)));
                            for (int unsigned c = x; c < x + w && c < FB_W; c++)
                                shadow_fb[p*FB_W+c] &= ~msk;
                        end
                    end
                end
            end
            REQ_READ: begin
                if (col < ew && pg <= eh / PAGE_ROWS && pg < FB_PAGES) begin
                    r.status = STAT_DONE;
                    r.rd_byte = shadow_fb[pg*FB_W+col];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Track register writes, requests and results on every rising edge.
    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            foreach (shadow_fb[i]) shadow_fb[i] = 8'd0;
            cols_used = FB_W;
            rows_used = FB_H;
            expected_q.delete();
            fail_count = 0;
            pending_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_WIDTH) cols_used = cfg_data;
                else if (cfg_index == CFG_HEIGHT) rows_used = cfg_data[6:0];
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(apply_request(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = expected_q.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("status %0b, expected %0b",
                                                  m_tuser, want.status));
                    if (m_tdata !== want.rd_byte)
                        report_mismatch($sformatf("read byte %h, expected %h",
                                                  m_tdata, want.rd_byte));
                end
            end
            pending_count = expected_q.size();
        end
    end

endmodule

>>> tb/page_framebuffer_blit_clear_tb.sv
// Testbench top for the page framebuffer blit/clear block: drives requests and
// register writes, and gives the verdict. Depends on pfbc_pkg and pfbc_checker.
`timescale 1ns / 1ps

module page_framebuffer_blit_clear_tb;
    import pfbc_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0, s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata = '0;
    logic [1:0] s_tuser = REQ_READ;
    logic m_tvalid, m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic m_tuser;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = CFG_WIDTH;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    int fail_count, pending_count;
    int send_idle_pct = 0, recv_stall_pct = 0;
    int unsigned cur_w = 128, cur_h = 64;

    always #5 aclk = ~aclk;

    page_framebuffer_blit_clear i_dut (.*);

    pfbc_checker i_checker (.*);

    // Random stalls on the result side, redrawn each cycle.
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Send one request and hold it until it is taken. Valid stays high
    // afterwards so that requests can follow back to back; idle cycles and
    // the drain lower it.
    task automatic send_request(input logic [1:0] kind, input int unsigned x,
                                input int unsigned y, input int unsigned w,
                                input int unsigned h, input int unsigned col,
                                input int unsigned pg, input int unsigned b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tuser <= kind;
        s_tdata <= {7'd0, 8'(b), 4'(pg), 7'(col), 7'(h), 8'(w), 7'(y), 8'(x)};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned val);
        cfg_index <= idx;
        cfg_data <= 8'(val);
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        if (idx == CFG_WIDTH) cur_w = val; else cur_h = val & 'h7F;
    endtask

    // Mostly in-bounds merges, clears and reads, small clears, some noise.
    task automatic random_request();
        int unsigned ew, eh, k, x, y, w, h;
        ew = cur_w > 128 ? 128 : cur_w;
        eh = cur_h > 64 ? 64 : cur_h;
        k = $urandom_range(99);
        if (k < 8) begin
            send_request(2'($urandom), $urandom_range(255), $urandom_range(127),
                         $urandom_range(255), $urandom_range(127), $urandom_range(127),
                         $urandom_range(15), $urandom_range(255));
        end else begin
            x = $urandom_range(ew - 1);
            y = $urandom_range(eh - 1);
            w = $urandom_range(ew - x);
            h = $urandom_range(eh - y);
            if (k < 45)
                send_request(REQ_MERGE, x, y, w, h, $urandom_range(w > 0 ? w - 1 : 0),
                             $urandom_range(h / 8), $urandom_range(255));
            else if (k < 60)
                send_request(REQ_CLEAR, x, y, $urandom_range(w < 12 ? w : 12), h, 0, 0, 0);
            else
                send_request(REQ_READ, 0, 0, 0, 0, $urandom_range(ew - 1),
                             $urandom_range(eh / 8), 0);
        end
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        // Directed: extremes and every special case.
        send_request(REQ_MERGE, 0, 0, 1, 1, 0, 0, 255);
        send_request(REQ_MERGE, 120, 61, 8, 3, 7, 0, 8'hA5);
        send_request(REQ_MERGE, 0, 60, 128, 4, 127, 0, 8'hFF);
        send_request(REQ_MERGE, 5, 3, 10, 20, 9, 2, 8'h81);
        send_request(REQ_MERGE, 100, 0, 29, 8, 0, 0, 1);
        send_request(REQ_MERGE, 0, 0, 4, 8, 4, 0, 1);
        send_request(REQ_MERGE, 0, 0, 4, 8, 0, 2, 1);
        send_request(REQ_MERGE, 0, 60, 4, 5, 0, 0, 1);
        send_request(REQ_READ, 0, 0, 0, 0, 127, 8, 0);
        send_request(REQ_READ, 0, 0, 0, 0, 127, 7, 0);
        send_request(REQ_READ, 0, 0, 0, 0, 127, 9, 0);
        send_request(REQ_READ, 0, 0, 0, 0, 15, 1, 0);
        send_request(REQ_CLEAR, 0, 0, 0, 64, 0, 0, 0);
        send_request(REQ_CLEAR, 3, 62, 2, 2, 0, 0, 0);
        send_request(REQ_CLEAR, 4, 5, 3, 0, 0, 0, 0);
        send_request(REQ_CLEAR, 127, 0, 2, 1, 0, 0, 0);
        send_request(REQ_CLEAR, 6, 2, 5, 13, 0, 0, 0);
        send_request(2'd3, 255, 127, 255, 127, 127, 15, 255);
        send_request(REQ_READ, 0, 0, 0, 0, 8, 1, 0);
        send_request(REQ_READ, 0, 0, 0, 0, 120, 7, 0);
        drain_results();
        write_reg(CFG_WIDTH, 1);
        write_reg(CFG_HEIGHT, 1);
        send_request(REQ_MERGE, 0, 0, 1, 1, 0, 0, 8'h3C);
        send_request(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
        send_request(REQ_READ, 0, 0, 0, 0, 1, 0, 0);
        drain_results();
        write_reg(CFG_WIDTH, 255);
        write_reg(CFG_HEIGHT, 127);
        // Random phases under different idling patterns and register settings.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 3)
                0: begin send_idle_pct = 24; recv_stall_pct = 59; end
                1: begin send_idle_pct = 59; recv_stall_pct = 24; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            repeat (80) random_request();
            drain_results();
            write_reg(CFG_WIDTH, $urandom_range(1, 255));
            write_reg(CFG_HEIGHT, $urandom_range(1, 127));
        end
        write_reg(CFG_WIDTH, 128);
        write_reg(CFG_HEIGHT, 64);
        repeat (30) random_request();
        drain_results();
        if (fail_count == 0) begin
            $display("** page_framebuffer_blit_clear: PASSED **");
        end else begin
            $display("** page_framebuffer_blit_clear: FAILED **");
        end
        $finish;
    end

    // Run limit: far beyond the slowest correct run.
    initial begin
        #20ms;
        $display("** page_framebuffer_blit_clear: FAILED **");
        $finish;
    end

endmodule
